// ----- rtl/core/lzsd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants for the LZSS stream decoder.
// ----------------------------------------------------------------------------
package lzsd_pkg;

  localparam int LIT_TOKEN_BITS = 9;
  localparam int BYTE_BITS      = 8;

  typedef struct packed {
    logic load;
    logic shift;
    logic lit_out;
    logic align_step;
    logic rd_issue;
    logic cp_read;
    logic cp_emit;
  } lzsd_cmd_t;

  typedef struct packed {
    logic lit_hit;
    logic match_hit;
    logic len_zero;
    logic last_bit;
    logic bits_left;
    logic addr_high;
    logic idx_last;
    logic out_free;
  } lzsd_sts_t;

endpackage

// ----- rtl/core/lzss_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// lzss_stream_decoder
// LZSS decompressor over a ring history; one compressed byte per input
// transaction, zero or more decompressed bytes per input byte, one per output transaction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | in_stream_byte[7:0]
//  out     | output    | out_valid / out_ready | out_byte[7:0], out_run_last
//
//  An input byte is loaded, then taken in one bit at a time, plus an emit step per literal.
//  A match adds position reduction steps (none at default sizes), a history read
//  pass into the copy buffer, then a copy pass that emits and writes back each byte.
//  Reset clears the controller; unwritten history reads as zero via a fill count.
//  A stalled output holds emission; intake resumes once the last byte is registered.
module lzss_stream_decoder import lzsd_pkg::*; #(
  parameter int HISTORY_DEPTH = 4096,
  parameter int POSITION_BITS = 12,
  parameter int LENGTH_BITS   = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_BITS-1:0] in_stream_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_BITS-1:0] out_byte,
  output logic                 out_run_last
);

  lzsd_cmd_t cmd;
  lzsd_sts_t sts;

  lzsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzsd_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stream_byte (in_stream_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last)
  );

endmodule

// ----- rtl/core/lzsd_ram.sv -----
// ----------------------------------------------------------------------------
// lzsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/lzsd_dp.sv -----
// ----------------------------------------------------------------------------
// lzsd_dp
// Decoder datapath: bit-serial token assembly, history and copy buffers,
// address generation and the output register.
// ----------------------------------------------------------------------------
module lzsd_dp import lzsd_pkg::*; #(
  parameter int HISTORY_DEPTH = 4096,
  parameter int POSITION_BITS = 12,
  parameter int LENGTH_BITS   = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [BYTE_BITS-1:0] in_stream_byte,
  input  lzsd_cmd_t            cmd,
  output lzsd_sts_t            sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_BITS-1:0] out_byte,
  output logic                 out_run_last
);

  localparam int TB  = 1 + POSITION_BITS + LENGTH_BITS;
  localparam int CW  = $clog2(TB + 1);
  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int FW  = $clog2(HISTORY_DEPTH + 1);
  localparam int RW  = (POSITION_BITS > AW) ? POSITION_BITS : AW;
  localparam int XW  = RW + 1;
  localparam int CPD = 1 << LENGTH_BITS;
  localparam logic [XW-1:0] DEPTH_X = XW'(HISTORY_DEPTH);
  localparam logic [FW-1:0] DEPTH_F = FW'(HISTORY_DEPTH);
  localparam logic [CW-1:0] LIT_CNT = CW'(LIT_TOKEN_BITS);
  localparam logic [CW-1:0] TOK_CNT = CW'(TB);

  // control registers
  logic [3:0]             bits_r, bits_nxt;
  logic [TB-1:0]          tok_r, tok_nxt;
  logic [CW-1:0]          tcnt_r, tcnt_nxt;
  logic                   flag_r, flag_nxt;
  logic [AW-1:0]          head_r, head_nxt;
  logic [FW-1:0]          fill_r, fill_nxt;
  logic [LENGTH_BITS-1:0] idx_r, idx_nxt;
  logic                   rd_pend_r;
  logic                   out_valid_r, out_valid_nxt;

  // payload registers
  logic [BYTE_BITS-1:0]   sbyte_r, sbyte_nxt;
  logic [BYTE_BITS-1:0]   lit_r, lit_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [RW-1:0]          addr_r, addr_nxt;
  logic                   rd_ok_r;
  logic [LENGTH_BITS-1:0] rd_idx_r;
  logic [BYTE_BITS-1:0]   out_byte_r, out_byte_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   bit_in;
  logic [TB-1:0]          tok_shift;
  logic [CW-1:0]          tcnt_inc;
  logic                   flag_eff;
  logic                   lit_hit;
  logic                   match_hit;
  logic [LENGTH_BITS-1:0] len_new;
  logic [XW-1:0]          addr_x;
  logic [XW-1:0]          addr_inc;
  logic [RW-1:0]          addr_wrap;
  logic                   addr_high;
  logic                   rd_ok;
  logic [XW-1:0]          head_inc;
  logic                   idx_last;
  logic                   out_free;
  logic                   hist_we;
  logic [BYTE_BITS-1:0]   hist_wdata;
  logic [BYTE_BITS-1:0]   hist_rdata;
  logic [BYTE_BITS-1:0]   cp_wdata;
  logic [BYTE_BITS-1:0]   cp_rdata;

  assign bit_in    = sbyte_r[BYTE_BITS-1];
  assign tok_shift = {tok_r[TB-2:0], bit_in};
  assign tcnt_inc  = tcnt_r + CW'(1);
  assign flag_eff  = (tcnt_r == '0) ? bit_in : flag_r;
  assign lit_hit   = flag_eff && (tcnt_inc == LIT_CNT);
  assign match_hit = !flag_eff && (tcnt_inc == TOK_CNT);
  assign len_new   = tok_shift[LENGTH_BITS-1:0];

  assign addr_x    = XW'(addr_r);
  assign addr_inc  = addr_x + XW'(1);
  assign addr_wrap = (addr_inc == DEPTH_X) ? '0 : addr_inc[RW-1:0];
  assign addr_high = (addr_x >= DEPTH_X);
  // entries at or beyond the fill count were never written and read as zero
  assign rd_ok     = (addr_x < XW'(fill_r));
  assign head_inc  = XW'(head_r) + XW'(1);

  assign idx_last  = (idx_r == (len_r - LENGTH_BITS'(1)));
  assign out_free  = !out_valid_r || out_ready;

  assign sts.lit_hit   = lit_hit;
  assign sts.match_hit = match_hit;
  assign sts.len_zero  = (len_new == '0);
  assign sts.last_bit  = (bits_r == 4'd1);
  assign sts.bits_left = (bits_r != 4'd0);
  assign sts.addr_high = addr_high;
  assign sts.idx_last  = idx_last;
  assign sts.out_free  = out_free;

  assign hist_we    = cmd.lit_out || cmd.cp_emit;
  assign hist_wdata = cmd.lit_out ? lit_r : cp_rdata;
  assign cp_wdata   = rd_ok_r ? hist_rdata : '0;

  always_comb begin
    bits_nxt      = bits_r;
    sbyte_nxt     = sbyte_r;
    tok_nxt       = tok_r;
    tcnt_nxt      = tcnt_r;
    flag_nxt      = flag_r;
    lit_nxt       = lit_r;
    len_nxt       = len_r;
    addr_nxt      = addr_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (cmd.load) begin
      sbyte_nxt = in_stream_byte;
      bits_nxt  = 4'd8;
    end

    if (cmd.shift) begin
      sbyte_nxt = {sbyte_r[BYTE_BITS-2:0], 1'b0};
      bits_nxt  = bits_r - 4'd1;
      if (tcnt_r == '0) begin
        flag_nxt = bit_in;
      end
      if (lit_hit || match_hit) begin
        tok_nxt  = '0;
        tcnt_nxt = '0;
      end else begin
        tok_nxt  = tok_shift;
        tcnt_nxt = tcnt_inc;
      end
      if (lit_hit) begin
        lit_nxt = tok_shift[BYTE_BITS-1:0];
      end
      if (match_hit) begin
        len_nxt  = len_new;
        addr_nxt = RW'(tok_shift[LENGTH_BITS +: POSITION_BITS]);
        idx_nxt  = '0;
      end
    end

    if (cmd.align_step) begin
      addr_nxt = RW'(addr_x - DEPTH_X);
    end

    if (cmd.rd_issue) begin
      addr_nxt = addr_wrap;
      idx_nxt  = idx_last ? '0 : idx_r + LENGTH_BITS'(1);
    end

    if (cmd.cp_emit) begin
      idx_nxt = idx_r + LENGTH_BITS'(1);
    end

    if (hist_we) begin
      head_nxt = (head_inc == DEPTH_X) ? '0 : head_inc[AW-1:0];
      if (fill_r != DEPTH_F) begin
        fill_nxt = fill_r + FW'(1);
      end
    end

    if (cmd.lit_out) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = lit_r;
      out_last_nxt  = 1'b1;
    end else if (cmd.cp_emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cp_rdata;
      out_last_nxt  = idx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r      <= '0;
      tok_r       <= '0;
      tcnt_r      <= '0;
      flag_r      <= 1'b0;
      head_r      <= '0;
      fill_r      <= '0;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bits_r      <= bits_nxt;
      tok_r       <= tok_nxt;
      tcnt_r      <= tcnt_nxt;
      flag_r      <= flag_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      rd_pend_r   <= cmd.rd_issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sbyte_r    <= sbyte_nxt;
    lit_r      <= lit_nxt;
    len_r      <= len_nxt;
    addr_r     <= addr_nxt;
    rd_ok_r    <= rd_ok;
    rd_idx_r   <= idx_r;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  lzsd_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (head_r),
    .wdata (hist_wdata),
    .re    (cmd.rd_issue),
    .raddr (addr_r[AW-1:0]),
    .rdata (hist_rdata)
  );

  lzsd_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (CPD)
  ) u_copy (
    .clk   (clk),
    .we    (rd_pend_r),
    .waddr (rd_idx_r),
    .wdata (cp_wdata),
    .re    (cmd.cp_read),
    .raddr (idx_r),
    .rdata (cp_rdata)
  );

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_F)
    else $error("fill count beyond history depth");

  a_tcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tcnt_r < TOK_CNT)
    else $error("token bit count overran token length");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> !addr_high)
    else $error("history read before address reduction");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.lit_out || cmd.cp_emit) |-> out_free)
    else $error("emit into occupied output register");

endmodule

// ----- rtl/core/lzsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lzsd_ctrl
// Decoder controller: sequences bit intake, literal emit, position reduction,
// match read and match emit/write-back.
// ----------------------------------------------------------------------------
module lzsd_ctrl import lzsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lzsd_sts_t sts,
  output lzsd_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_LIT,
    S_ALIGN,
    S_READ,
    S_DRAIN,
    S_CREAD,
    S_CEMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        priority if (sts.lit_hit) begin
          state_nxt = S_LIT;
        end else if (sts.match_hit && !sts.len_zero) begin
          state_nxt = S_ALIGN;
        end else if (sts.last_bit) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_LIT: begin
        if (sts.out_free) begin
          cmd.lit_out = 1'b1;
          state_nxt   = sts.bits_left ? S_SHIFT : S_IDLE;
        end
      end
      S_ALIGN: begin
        if (sts.addr_high) begin
          cmd.align_step = 1'b1;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_CREAD;
      end
      S_CREAD: begin
        cmd.cp_read = 1'b1;
        state_nxt   = S_CEMIT;
      end
      S_CEMIT: begin
        if (sts.out_free) begin
          cmd.cp_emit = 1'b1;
          if (sts.idx_last) begin
            state_nxt = sts.bits_left ? S_SHIFT : S_IDLE;
          end else begin
            state_nxt = S_CREAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- dv/tb_lzss_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_lzss_stream_decoder
// Self-checking bench for the LZSS stream decoder. Token streams (literals,
// matches, noise bits) are packed into bytes and pushed through the input
// channel with random stalls on both sides. Every accepted byte is decoded by
// a behavioral model that keeps its own history. Each output transaction is
// compared in order against the queue of decoded bytes.
// ----------------------------------------------------------------------------
module tb_lzss_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import lzsd_pkg::*;

  localparam int HIST_DEPTH = 4096;
  localparam int POS_BITS   = 12;
  localparam int LEN_BITS   = 4;
  localparam int MATCH_BITS = 1 + POS_BITS + LEN_BITS;
  localparam int RUN_MAX    = (1 << LEN_BITS) - 1;
  localparam int RAND_BYTES = 410;
  localparam int QUIET_TAIL = 70;

  class decode_scoreboard;
    typedef struct packed {
      logic [BYTE_BITS-1:0] data;
      logic                 last;
    } dec_byte_t;

    logic [BYTE_BITS-1:0]  hist [HIST_DEPTH];
    logic [POS_BITS-1:0]   head;
    logic [MATCH_BITS-1:0] tok;
    int unsigned           nbits;
    dec_byte_t             expected_bytes[$];
    int unsigned           fails;

    function void clear();
      foreach (hist[i]) hist[i] = '0;
      head  = '0;
      tok   = '0;
      nbits = 0;
      fails = 0;
      expected_bytes.delete();
    endfunction

    // decode one stream byte, MSB first, queueing the bytes it releases
    function void absorb_byte(logic [BYTE_BITS-1:0] b);
      logic [BYTE_BITS-1:0] run[$];
      logic [BYTE_BITS-1:0] copy_buf [RUN_MAX];
      logic                 flag;
      logic [LEN_BITS-1:0]  len;
      logic [POS_BITS-1:0]  rd;
      dec_byte_t            item;
      for (int i = BYTE_BITS - 1; i >= 0; i--) begin
        tok   = {tok[MATCH_BITS-2:0], b[i]};
        nbits++;
        flag  = tok[nbits-1];
        if (flag && nbits == LIT_TOKEN_BITS) begin
          run.push_back(tok[BYTE_BITS-1:0]);
          hist[head] = tok[BYTE_BITS-1:0];
          head++;
          tok   = '0;
          nbits = 0;
        end else if (!flag && nbits == MATCH_BITS) begin
          len = tok[LEN_BITS-1:0];
          rd  = tok[LEN_BITS +: POS_BITS];
          // all reads happen before any write-back
          for (int k = 0; k < len; k++) begin
            copy_buf[k] = hist[rd];
            run.push_back(hist[rd]);
            rd++;
          end
          for (int k = 0; k < len; k++) begin
            hist[head] = copy_buf[k];
            head++;
          end
          tok   = '0;
          nbits = 0;
        end
      end
      foreach (run[j]) begin
        item.data = run[j];
        item.last = (j == run.size() - 1);
        expected_bytes.push_back(item);
      end
    endfunction

    function void check_output(logic [BYTE_BITS-1:0] data, logic last);
      dec_byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output transaction: out_byte=%02h out_run_last=%0b", data, last);
        fails++;
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte mismatch: expected %02h, actual %02h", want.data, data);
        fails++;
      end
      if (last !== want.last) begin
        $error("out_run_last mismatch: expected %0b, actual %0b", want.last, last);
        fails++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_BITS-1:0] in_stream_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [BYTE_BITS-1:0] out_byte;
  logic                 out_run_last;

  decode_scoreboard     sb = new;
  bit                   stream_bits[$];
  int unsigned          bytes_sent;
  logic [POS_BITS-1:0]  gen_head;
  bit                   in_idle_on;
  bit                   out_idle_on;
  int unsigned          stall_left;

  lzss_stream_decoder #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .POSITION_BITS(POS_BITS),
    .LENGTH_BITS  (LEN_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_stream_byte(in_stream_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_output(out_byte, out_run_last);
  end

  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready = 1'b0;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic put_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) stream_bits.push_back(v[i]);
  endtask

  task automatic put_literal(logic [BYTE_BITS-1:0] v);
    put_bits(32'({1'b1, v}), LIT_TOKEN_BITS);
    gen_head++;
  endtask

  task automatic put_match(logic [POS_BITS-1:0] pos, logic [LEN_BITS-1:0] len);
    put_bits(32'({1'b0, pos, len}), MATCH_BITS);
    gen_head += POS_BITS'(len);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_byte(logic [BYTE_BITS-1:0] b);
    in_valid       = 1'b1;
    in_stream_byte = b;
    do @(posedge clk); while (!in_ready);
    sb.absorb_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic hold_input(int unsigned cycles);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic send_ready_bytes();
    logic [BYTE_BITS-1:0] b;
    while (stream_bits.size() >= BYTE_BITS) begin
      for (int i = 0; i < BYTE_BITS; i++) b = {b[BYTE_BITS-2:0], stream_bits.pop_front()};
      push_byte(b);
      if (in_idle_on && $urandom_range(0, 3) == 0) hold_input($urandom_range(1, 16));
    end
  endtask

  task automatic wait_decoded_empty();
    int unsigned guard;
    guard = 0;
    while (sb.expected_bytes.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic put_random_token();
    logic [POS_BITS-1:0] pos;
    logic [LEN_BITS-1:0] len;
    int unsigned         pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      put_bits($urandom_range(0, 255), BYTE_BITS);
    end else if (pick < 11) begin
      put_literal(BYTE_BITS'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: pos = POS_BITS'(gen_head - $urandom_range(1, 40));
        6, 7:             pos = POS_BITS'($urandom_range(0, HIST_DEPTH - 1));
        default:          pos = POS_BITS'(HIST_DEPTH - $urandom_range(1, RUN_MAX));
      endcase
      case ($urandom_range(0, 9))
        0, 1:    len = LEN_BITS'(RUN_MAX);
        2:       len = '0;
        default: len = LEN_BITS'($urandom_range(0, RUN_MAX));
      endcase
      put_match(pos, len);
    end
  endtask

  initial begin
    bit paused;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_stream_byte = '0;
    in_idle_on     = 1'b1;
    out_idle_on    = 1'b1;
    gen_head       = '0;
    bytes_sent     = 0;
    paused         = 1'b0;
    sb.clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: literal extremes, empty match, copies, wrap, overlap, raw bytes
    put_match(12'd7, 4'd3);
    put_literal(8'h00);
    put_literal(8'hFF);
    put_literal(8'hA5);
    put_literal(8'h5A);
    put_match(12'd0, 4'd0);
    put_match(12'd3, 4'd4);
    put_match(POS_BITS'(HIST_DEPTH - 1), LEN_BITS'(RUN_MAX));
    put_match(gen_head - 12'd1, LEN_BITS'(RUN_MAX));
    put_bits(32'hFF, BYTE_BITS);
    put_bits(32'h00, BYTE_BITS);
    put_literal(8'h80);
    put_match(12'hFFF, 4'd1);
    send_ready_bytes();

    while (bytes_sent < 20 + RAND_BYTES) begin
      if (bytes_sent % 60 == 0) begin
        in_idle_on  = $urandom_range(0, 2) != 0;
        out_idle_on = $urandom_range(0, 2) != 0;
      end
      if (bytes_sent >= 20 + RAND_BYTES - QUIET_TAIL) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end
      if (!paused && bytes_sent >= 200) begin
        paused = 1'b1;
        in_valid = 1'b0;
        wait_decoded_empty();
        @(negedge clk);
        hold_input(80);
      end
      put_random_token();
      send_ready_bytes();
    end

    while (stream_bits.size() % BYTE_BITS != 0) stream_bits.push_back(1'b0);
    send_ready_bytes();
    in_valid = 1'b0;
    wait_decoded_empty();
    repeat (120) @(posedge clk);

    if (sb.fails == 0 && sb.expected_bytes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (sb.expected_bytes.size() != 0)
        $error("%0d decoded bytes never appeared on out_byte", sb.expected_bytes.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/lzsd_pkg.sv
rtl/core/lzsd_ram.sv
rtl/core/lzsd_dp.sv
rtl/core/lzsd_ctrl.sv
rtl/core/lzss_stream_decoder.sv
dv/tb_lzss_stream_decoder.sv
